FILE: hw/rtl/binary_min_heap_queue_unit_defines.svh
// binary_min_heap_queue_unit_defines.svh: assertion macros for the heap queue checker
// depends on nothing; included by bmhq_checker.sv
`ifndef BINARY_MIN_HEAP_QUEUE_UNIT_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_UNIT_DEFINES_SVH

// implication checked every cycle out of reset
`define BMHQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen
`define BMHQ_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/bmhq_pkg.sv
// bmhq_pkg.sv: sizes, codes and memory request type of the heap queue
// used by bmhq_ctrl, binary_min_heap_queue_unit and bmhq_checker
package bmhq_pkg;

  localparam int CAPACITY = 256;
  localparam int TAG_W    = 32;
  localparam int PRIO_W   = 32;
  localparam int ENTRY_W  = TAG_W + PRIO_W;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = ADDR_W + 2;
  localparam int FILL_W   = 9;
  localparam int STATUS_W = 2;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ADDR_W-1:0]  ra_addr;
    logic [ADDR_W-1:0]  rb_addr;
  } ram_req_t;

endpackage

FILE: hw/rtl/binary_min_heap_queue_unit.sv
// Binary min-heap priority queue of 256 {tag, prio} entries kept in one synchronous ram
// with one write port and two read ports. A push sifts the new entry up, a pop returns the
// root and sifts the last entry down from the root; every request yields exactly one result
// with a status (ok, full, empty) and the fill after the request. Each heap level costs a
// ram read and one compare-and-write. A pop first reads the root and the last entry, then
// sifts down. A new request is taken once the previous one has reached the output register,
// even while that result is still stalled, and it can be taken in the cycle after the one
// that loads the output register. The ram holds no reset contents and needs no clearing
// pass.
// depends on bmhq_pkg, bmhq_ram and bmhq_ctrl
module binary_min_heap_queue_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [bmhq_pkg::TAG_W-1:0]    in_tag,
  input  logic [bmhq_pkg::PRIO_W-1:0]   in_prio,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bmhq_pkg::TAG_W-1:0]    out_tag,
  output logic [bmhq_pkg::PRIO_W-1:0]   out_prio,
  output logic [bmhq_pkg::STATUS_W-1:0] out_status,
  output logic [bmhq_pkg::FILL_W-1:0]   out_fill
);

  bmhq_pkg::ram_req_t                ram_req;
  logic [bmhq_pkg::ENTRY_W-1:0]      ra_data;
  logic [bmhq_pkg::ENTRY_W-1:0]      rb_data;

  bmhq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_tag      (in_tag),
    .in_prio     (in_prio),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_tag     (out_tag),
    .out_prio    (out_prio),
    .out_status  (out_status),
    .out_fill    (out_fill),
    .ram_req     (ram_req),
    .ra_data     (ra_data),
    .rb_data     (rb_data)
  );

  bmhq_ram #(
    .DEPTH (bmhq_pkg::CAPACITY),
    .WIDTH (bmhq_pkg::ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_req.we),
    .waddr   (ram_req.waddr),
    .wdata   (ram_req.wdata),
    .ra_addr (ram_req.ra_addr),
    .ra_data (ra_data),
    .rb_addr (ram_req.rb_addr),
    .rb_data (rb_data)
  );

endmodule

FILE: hw/rtl/bmhq_ram.sv
// bmhq_ram.sv: generic synchronous ram, one write port and two registered read ports
// depends on nothing
module bmhq_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    ra_addr,
  output logic [WIDTH-1:0] ra_data,
  input  logic [AW-1:0]    rb_addr,
  output logic [WIDTH-1:0] rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

FILE: hw/rtl/bmhq_ctrl.sv
// bmhq_ctrl.sv: request sequencer for sift-up and sift-down, entry count and result register
// depends on bmhq_pkg; drives the heap ram through bmhq_pkg::ram_req_t
module bmhq_ctrl (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_req_type,
  input  logic [bmhq_pkg::TAG_W-1:0]            in_tag,
  input  logic [bmhq_pkg::PRIO_W-1:0]           in_prio,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [bmhq_pkg::TAG_W-1:0]            out_tag,
  output logic [bmhq_pkg::PRIO_W-1:0]           out_prio,
  output logic [bmhq_pkg::STATUS_W-1:0]         out_status,
  output logic [bmhq_pkg::FILL_W-1:0]           out_fill,
  output bmhq_pkg::ram_req_t                    ram_req,
  input  logic [bmhq_pkg::ENTRY_W-1:0]          ra_data,
  input  logic [bmhq_pkg::ENTRY_W-1:0]          rb_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_POP_RD, S_POP_CMP, S_DN_RD, S_DN_CMP, S_DONE
  } state_t;

  localparam int AW = bmhq_pkg::ADDR_W;
  localparam int CW = bmhq_pkg::COUNT_W;
  localparam int PW = bmhq_pkg::PRIO_W;
  localparam int TW = bmhq_pkg::TAG_W;

  state_t                         state_r, state_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [AW-1:0]                  pos_r, pos_nxt;
  logic [bmhq_pkg::ENTRY_W-1:0]   mover_r, mover_nxt;
  logic                           has_c2_r, has_c2_nxt;
  logic [TW-1:0]                  res_tag_r, res_tag_nxt;
  logic [PW-1:0]                  res_prio_r, res_prio_nxt;
  logic [bmhq_pkg::STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [TW-1:0]                  out_tag_r, out_tag_nxt;
  logic [PW-1:0]                  out_prio_r, out_prio_nxt;
  logic [bmhq_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [bmhq_pkg::FILL_W-1:0]    out_fill_r, out_fill_nxt;

  logic [AW-1:0]                  parent;
  logic [bmhq_pkg::CHILD_W-1:0]   c1, c2;
  logic [PW-1:0]                  a_prio, b_prio, mover_prio;
  logic                           pick_b;
  logic [bmhq_pkg::ENTRY_W-1:0]   pick_data;
  logic [AW-1:0]                  pick_addr;
  logic                           out_take;

  assign parent     = AW'((pos_r - AW'(1)) >> 1);
  assign c1         = {1'b0, pos_r, 1'b1};
  assign c2         = c1 + bmhq_pkg::CHILD_W'(1);
  assign a_prio     = ra_data[PW-1:0];
  assign b_prio     = rb_data[PW-1:0];
  assign mover_prio = mover_r[PW-1:0];
  assign pick_b     = has_c2_r && !(a_prio < b_prio);
  assign pick_data  = pick_b ? rb_data : ra_data;
  assign pick_addr  = pick_b ? c2[AW-1:0] : c1[AW-1:0];
  assign out_take   = out_valid_r && !out_stall;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    mover_nxt      = mover_r;
    has_c2_nxt     = has_c2_r;
    res_tag_nxt    = res_tag_r;
    res_prio_nxt   = res_prio_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_take ? 1'b0 : out_valid_r;
    out_tag_nxt    = out_tag_r;
    out_prio_nxt   = out_prio_r;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;
    ram_req.we      = 1'b0;
    ram_req.waddr   = pos_r;
    ram_req.wdata   = mover_r;
    ram_req.ra_addr = parent;
    ram_req.rb_addr = count_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mover_nxt      = {in_tag, in_prio};
          res_tag_nxt    = '0;
          res_prio_nxt   = '0;
          res_status_nxt = bmhq_pkg::ST_OK;
          if (in_req_type == bmhq_pkg::REQ_PUSH) begin
            if (count_r == CW'(bmhq_pkg::CAPACITY)) begin
              res_status_nxt = bmhq_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              pos_nxt   = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
              state_nxt = S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = bmhq_pkg::ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              count_nxt = count_r - CW'(1);
              state_nxt = S_POP_RD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          ram_req.we = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_req.we = 1'b1;
        if (mover_prio < a_prio) begin
          ram_req.wdata = ra_data;
          pos_nxt       = parent;
          state_nxt     = S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POP_RD: begin
        ram_req.ra_addr = '0;
        state_nxt       = S_POP_CMP;
      end
      S_POP_CMP: begin
        res_tag_nxt  = ra_data[bmhq_pkg::ENTRY_W-1:PW];
        res_prio_nxt = a_prio;
        mover_nxt    = rb_data;
        pos_nxt      = '0;
        state_nxt    = (count_r == '0) ? S_DONE : S_DN_RD;
      end
      S_DN_RD: begin
        ram_req.ra_addr = c1[AW-1:0];
        ram_req.rb_addr = c2[AW-1:0];
        has_c2_nxt      = c2 < bmhq_pkg::CHILD_W'(count_r);
        if (c1 >= bmhq_pkg::CHILD_W'(count_r)) begin
          ram_req.we = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        ram_req.we = 1'b1;
        if (pick_data[PW-1:0] < mover_prio) begin
          ram_req.wdata = pick_data;
          pos_nxt       = pick_addr;
          state_nxt     = S_DN_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_take) begin
          out_valid_nxt  = 1'b1;
          out_tag_nxt    = res_tag_r;
          out_prio_nxt   = res_prio_r;
          out_status_nxt = res_status_r;
          out_fill_nxt   = bmhq_pkg::FILL_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    mover_r      <= mover_nxt;
    has_c2_r     <= has_c2_nxt;
    res_tag_r    <= res_tag_nxt;
    res_prio_r   <= res_prio_nxt;
    res_status_r <= res_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_prio_r   <= out_prio_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_tag    = out_tag_r;
  assign out_prio   = out_prio_r;
  assign out_status = out_status_r;
  assign out_fill   = out_fill_r;

endmodule

FILE: hw/rtl/bmhq_checker.sv
// bmhq_checker.sv: port-level checks of the heap queue, bound to binary_min_heap_queue_unit
// depends on bmhq_pkg and binary_min_heap_queue_unit_defines.svh
`include "binary_min_heap_queue_unit_defines.svh"

module bmhq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_req_type,
  input logic [bmhq_pkg::TAG_W-1:0]    in_tag,
  input logic [bmhq_pkg::PRIO_W-1:0]   in_prio,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [bmhq_pkg::TAG_W-1:0]    out_tag,
  input logic [bmhq_pkg::PRIO_W-1:0]   out_prio,
  input logic [bmhq_pkg::STATUS_W-1:0] out_status,
  input logic [bmhq_pkg::FILL_W-1:0]   out_fill
);

  logic                                  zero_entry;
  logic                                  empty_res;
  logic                                  full_res;
  logic                                  full_fill;
  logic                                  over_fill;
  logic [bmhq_pkg::TAG_W+bmhq_pkg::PRIO_W:0] in_bus;
  logic [bmhq_pkg::TAG_W+bmhq_pkg::PRIO_W+bmhq_pkg::STATUS_W+bmhq_pkg::FILL_W-1:0] out_bus;

  assign zero_entry = (out_tag == '0) && (out_prio == '0);
  assign empty_res  = out_valid && (out_status == bmhq_pkg::ST_EMPTY);
  assign full_res   = out_valid && (out_status == bmhq_pkg::ST_FULL);
  assign full_fill  = (out_fill == bmhq_pkg::FILL_W'(bmhq_pkg::CAPACITY));
  assign over_fill  = out_valid && (out_fill > bmhq_pkg::FILL_W'(bmhq_pkg::CAPACITY));
  assign in_bus     = {in_req_type, in_tag, in_prio};
  assign out_bus    = {out_tag, out_prio, out_status, out_fill};

  // empty pop reports nothing held and a zero entry
  `BMHQ_ASSERT(a_empty_pop, clk, rst_n, empty_res |-> (out_fill == '0 && zero_entry), "bad empty pop")
  // refused push leaves the queue full
  `BMHQ_ASSERT(a_full_push, clk, rst_n, full_res |-> (full_fill && zero_entry), "bad refused push")
  // fill stays within capacity
  `BMHQ_NEVER(a_fill_range, clk, rst_n, over_fill, "fill above capacity")
  // stalled result holds
  `BMHQ_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_bus)), "stalled result changed")
  // stalled request holds
  `BMHQ_ASSERT(a_in_hold, clk, rst_n, (in_valid && in_stall) |=> (in_valid && $stable(in_bus)), "stalled request changed")

endmodule

bind binary_min_heap_queue_unit bmhq_checker u_bmhq_checker (.*);
